[src/pmid_pkg.sv]
// ----------------------------------------------------------------------------
// pmid_pkg
// Shared widths, register indexes and cell payload types of the periodic
// minimum-image distance block.
// ----------------------------------------------------------------------------
package pmid_pkg;

  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  localparam int BOX_W      = COORD_W - 1;
  localparam int DIST_W     = COORD_W - 1;
  localparam int DIV_STEPS  = COORD_W + 1;
  localparam int SUM_W      = 2 * COORD_W;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam int IDX_W      = $clog2(SQRT_STEPS);
  localparam int SHIFT_W    = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 2;

  // Pipeline stages after the divider: remainder fix-up, square, sum.
  localparam int MID_STAGES = 3;
  localparam int N_STAGES   = DIV_STEPS + MID_STAGES + SQRT_STEPS;

  localparam logic [BOX_W-1:0] BOX_RESET = BOX_W'(1) << FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One axis as it travels along the divider row.
  typedef struct packed {
    logic [BOX_W-1:0] rem;
    logic [COORD_W:0] dvd;
    logic             neg;
    coord_t           sat;
  } div_t;

  // One step of the square root row.
  typedef struct packed {
    logic [SUM_W-1:0] rad;
    logic [SUM_W-1:0] root;
  } sqrt_t;

endpackage

[src/pmid_in_if.sv]
// ----------------------------------------------------------------------------
// pmid_in_if
// Request channel carrying the two points.
// ----------------------------------------------------------------------------
interface pmid_in_if;
  import pmid_pkg::*;
  logic   valid;
  logic   ready;
  coord_t a_x;
  coord_t a_y;
  coord_t a_z;
  coord_t b_x;
  coord_t b_y;
  coord_t b_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

[src/pmid_out_if.sv]
// ----------------------------------------------------------------------------
// pmid_out_if
// Result channel carrying the wrapped separation and its length.
// ----------------------------------------------------------------------------
interface pmid_out_if;
  import pmid_pkg::*;
  logic                valid;
  logic                ready;
  coord_t              sep_x;
  coord_t              sep_y;
  coord_t              sep_z;
  logic [DIST_W-1:0]   distance;
  modport source (output valid, sep_x, sep_y, sep_z, distance, input ready);
  modport sink   (input valid, sep_x, sep_y, sep_z, distance, output ready);
endinterface

[src/pmid_cfg_if.sv]
// ----------------------------------------------------------------------------
// pmid_cfg_if
// Register write channel for the box lengths.
// ----------------------------------------------------------------------------
interface pmid_cfg_if;
  import pmid_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BOX_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/pmid_div_cell.sv]
// ----------------------------------------------------------------------------
// pmid_div_cell
// One restoring step of the remainder computation for one axis.
// ----------------------------------------------------------------------------
module pmid_div_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pmid_pkg::BOX_W-1:0] len,
  input  pmid_pkg::div_t            d_in,
  output pmid_pkg::div_t            d_out
);
  import pmid_pkg::*;

  logic [BOX_W:0] trial;
  div_t           d_nxt;
  div_t           d_r;

  // Shift in the next dividend bit and subtract the length if it fits.
  always_comb begin
    trial = {d_in.rem, d_in.dvd[COORD_W]};
    d_nxt = d_in;
    d_nxt.dvd = {d_in.dvd[COORD_W-1:0], 1'b0};
    if (trial >= {1'b0, len}) begin
      d_nxt.rem = BOX_W'(trial - {1'b0, len});
    end else begin
      d_nxt.rem = trial[BOX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign d_out = d_r;

endmodule

[src/pmid_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// pmid_sqrt_cell
// One digit step of the integer square root of the sum of squares.
// ----------------------------------------------------------------------------
module pmid_sqrt_cell (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pmid_pkg::IDX_W-1:0] step,
  input  pmid_pkg::sqrt_t           s_in,
  output pmid_pkg::sqrt_t           s_out
);
  import pmid_pkg::*;

  logic [SUM_W-1:0]   bit_w;
  logic [SUM_W-1:0]   trial;
  logic [SHIFT_W-1:0] sh;
  sqrt_t              s_nxt;
  sqrt_t              s_r;

  // The trial bit moves down two places per step, starting at the top pair.
  always_comb begin
    sh    = SHIFT_W'(SUM_W - 2) - {step, 1'b0};
    bit_w = SUM_W'(1) << sh;
    trial = s_in.root + bit_w;
    if (s_in.rad >= trial) begin
      s_nxt.rad  = s_in.rad - trial;
      s_nxt.root = (s_in.root >> 1) + bit_w;
    end else begin
      s_nxt.rad  = s_in.rad;
      s_nxt.root = s_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s_nxt;
    end
  end

  assign s_out = s_r;

endmodule

[src/periodic_min_image_distance.sv]
// ----------------------------------------------------------------------------
// periodic_min_image_distance
// Minimum-image separation of two 3-D points in a periodic box, and its
// Euclidean length.
//
// Channels: in_if takes one request holding points a and b (signed Q15.16);
// out_if returns the wrapped separation b - a per axis and its length.
// cfg_if writes the box lengths: index 0, 1, 2 for x, y, z. It is always
// ready and must only be used while no request is in flight.
// Throughput: one request per cycle while out_if is not stalled. The path from
// acceptance to the result appearing at out_if runs through a row of 33
// remainder cells per axis (one dividend bit each), registers for the
// round-to-nearest fix-up, squaring and summing, and a row of 32 square
// root cells (one result bit each), followed by the output register.
// Reset: the pipeline empties and all box lengths return to 1.0.
// Stall: while a result waits at out_if the whole row holds and in_if.ready
// follows out_if.ready combinationally, so no request is lost.
// ----------------------------------------------------------------------------
module periodic_min_image_distance (
  input  logic clk,
  input  logic rst_n,
  pmid_in_if.sink    in_if,
  pmid_out_if.source out_if,
  pmid_cfg_if.sink   cfg_if
);
  import pmid_pkg::*;

  logic [BOX_W-1:0]    box_r   [3];
  logic [N_STAGES-1:0] vld_r;
  logic                adv;
  logic                in_fire;
  logic                out_valid_r;

  coord_t              a_c [3];
  coord_t              b_c [3];
  div_t                div_c [3][DIV_STEPS+1];
  coord_t              sep_r [3];
  logic [SUM_W-1:0]    sq_r  [3];
  coord_t              sep2_r [3];
  logic [SUM_W+1:0]    sum_w;
  logic [SUM_W-1:0]    sum_r;
  coord_t              sep3_r [3];
  sqrt_t               sq_c  [SQRT_STEPS+1];
  coord_t              sep_pipe_r [SQRT_STEPS][3];

  coord_t              sep_out_r [3];
  logic [DIST_W-1:0]   dist_r;

  // Whole row advances when the output register is free or being taken.
  assign adv          = !out_valid_r || out_if.ready;
  assign in_if.ready  = adv;
  assign in_fire      = in_if.valid && adv;
  assign cfg_if.ready = 1'b1;

  // Box length registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0] <= BOX_RESET;
      box_r[1] <= BOX_RESET;
      box_r[2] <= BOX_RESET;
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        REG_BOX_X: box_r[0] <= cfg_if.data;
        REG_BOX_Y: box_r[1] <= cfg_if.data;
        REG_BOX_Z: box_r[2] <= cfg_if.data;
        default:   ;
      endcase
    end
  end

  // Valid bits shift alongside the payload.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[N_STAGES-2:0], in_fire};
      out_valid_r <= vld_r[N_STAGES-1];
    end
  end

  assign a_c[0] = in_if.a_x;
  assign a_c[1] = in_if.a_y;
  assign a_c[2] = in_if.a_z;
  assign b_c[0] = in_if.b_x;
  assign b_c[1] = in_if.b_y;
  assign b_c[2] = in_if.b_z;

  genvar ax, st;
  generate
    for (ax = 0; ax < 3; ax++) begin : g_axis
      logic signed [COORD_W:0] diff;
      logic [BOX_W:0]          twice;
      logic signed [COORD_W-1:0] s_w;
      logic signed [COORD_W-1:0] sep_w;
      logic [COORD_W-1:0]      mag_w;

      // Exact difference, its magnitude and the saturated copy for an
      // unwrapped axis.
      always_comb begin
        diff = {b_c[ax][COORD_W-1], b_c[ax]} - {a_c[ax][COORD_W-1], a_c[ax]};
        div_c[ax][0].rem = '0;
        div_c[ax][0].neg = diff[COORD_W];
        div_c[ax][0].dvd = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
        if (diff[COORD_W] != diff[COORD_W-1]) begin
          div_c[ax][0].sat = diff[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                           : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
          div_c[ax][0].sat = diff[COORD_W-1:0];
        end
      end

      for (st = 0; st < DIV_STEPS; st++) begin : g_div
        pmid_div_cell u_cell (
          .clk   (clk),
          .en    (adv),
          .len   (box_r[ax]),
          .d_in  (div_c[ax][st]),
          .d_out (div_c[ax][st+1])
        );
      end

      // Round to nearest with halves away from zero, then restore the sign.
      always_comb begin
        twice = {div_c[ax][DIV_STEPS].rem, 1'b0};
        if (twice >= {1'b0, box_r[ax]}) begin
          s_w = {1'b0, div_c[ax][DIV_STEPS].rem} - {1'b0, box_r[ax]};
        end else begin
          s_w = {1'b0, div_c[ax][DIV_STEPS].rem};
        end
        if (box_r[ax] == '0) begin
          sep_w = div_c[ax][DIV_STEPS].sat;
        end else if (div_c[ax][DIV_STEPS].neg) begin
          sep_w = -s_w;
        end else begin
          sep_w = s_w;
        end
        mag_w = sep_r[ax][COORD_W-1] ? COORD_W'(-sep_r[ax]) : sep_r[ax];
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          sep_r[ax]  <= sep_w;
          sq_r[ax]   <= mag_w * mag_w;
          sep2_r[ax] <= sep_r[ax];
          sep3_r[ax] <= sep2_r[ax];
        end
      end
    end
  endgenerate

  // Sum of squares, widened by two bits; even with unwrapped axes it fits the
  // double width, and the register saturates if the top bits are ever set.
  always_comb begin
    sum_w = (SUM_W+2)'(sq_r[0]) + (SUM_W+2)'(sq_r[1]) + (SUM_W+2)'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sum_w[SUM_W+1:SUM_W] != '0) begin
        sum_r <= '1;
      end else begin
        sum_r <= sum_w[SUM_W-1:0];
      end
    end
  end

  assign sq_c[0].rad  = sum_r;
  assign sq_c[0].root = '0;

  generate
    for (st = 0; st < SQRT_STEPS; st++) begin : g_sqrt
      pmid_sqrt_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .step  (IDX_W'(st)),
        .s_in  (sq_c[st]),
        .s_out (sq_c[st+1])
      );

      // Separation vector rides along with the root.
      always_ff @(posedge clk) begin
        if (adv) begin
          if (st == 0) begin
            sep_pipe_r[st] <= sep3_r;
          end else begin
            sep_pipe_r[st] <= sep_pipe_r[(st == 0) ? 0 : st-1];
          end
        end
      end
    end
  endgenerate

  // Output register with saturation of the length.
  always_ff @(posedge clk) begin
    if (adv) begin
      sep_out_r <= sep_pipe_r[SQRT_STEPS-1];
      if (sq_c[SQRT_STEPS].root[SUM_W-1:DIST_W] != '0) begin
        dist_r <= '1;
      end else begin
        dist_r <= sq_c[SQRT_STEPS].root[DIST_W-1:0];
      end
    end
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.sep_x    = sep_out_r[0];
  assign out_if.sep_y    = sep_out_r[1];
  assign out_if.sep_z    = sep_out_r[2];
  assign out_if.distance = dist_r;

endmodule
